// ----- src/assert_macros.svh -----
// Assertion helpers for the FFT block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/r2fft_pkg.sv -----
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants and types of the radix-2 FFT engine.
// ----------------------------------------------------------------------------
package r2fft_pkg;

	localparam int POINTS   = 1024;
	localparam int LMAX     = $clog2(POINTS);
	localparam int AW       = LMAX;
	localparam int CW       = AW + 1;
	localparam int TW_BITS  = 16;
	localparam int TW_F     = TW_BITS - 1;
	localparam int TW_DEPTH = POINTS / 2;
	localparam int TW_AW    = (LMAX > 1) ? LMAX - 1 : 1;
	localparam int DW       = 32;
	localparam int OW       = 27;
	localparam int BIN_W    = 10;
	localparam int LOG_W    = 4;
	localparam int SMP_W    = 16;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic CFG_INVERSE = 1'b0;
	localparam logic CFG_LOG2    = 1'b1;

	typedef logic signed [DW-1:0]      word_t;
	typedef logic signed [TW_BITS-1:0] tw_t;
	typedef logic [2*DW-1:0]           cword_t;

	typedef struct packed {
		logic go;
		logic inv;
	} bf_ctl_t;

endpackage

// ----- src/r2fft_mem.sv -----
// ----------------------------------------------------------------------------
// r2fft_mem
// Frame store: one write port, two registered read ports, {re, im} words.
// ----------------------------------------------------------------------------
module r2fft_mem (
	input  logic                     clk,
	input  logic                     we,
	input  logic [r2fft_pkg::AW-1:0] waddr,
	input  r2fft_pkg::cword_t        wdata,
	input  logic [r2fft_pkg::AW-1:0] raddr0,
	input  logic [r2fft_pkg::AW-1:0] raddr1,
	output r2fft_pkg::cword_t        rdata0,
	output r2fft_pkg::cword_t        rdata1
);
	import r2fft_pkg::*;

	cword_t store_q [POINTS];
	cword_t rd0_q;
	cword_t rd1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rd0_q <= store_q[raddr0];
		rd1_q <= store_q[raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

// ----- src/r2fft_twiddle.sv -----
// ----------------------------------------------------------------------------
// r2fft_twiddle
// Twiddle ROM, Q1.15 cos/sin of 2*pi*m/POINTS, registered read.
// ----------------------------------------------------------------------------
module r2fft_twiddle (
	input  logic                        clk,
	input  logic [r2fft_pkg::TW_AW-1:0] addr,
	output r2fft_pkg::tw_t              w_cos,
	output r2fft_pkg::tw_t              w_sin
);
	import r2fft_pkg::*;

	typedef logic [2*TW_BITS-1:0] rom_t [TW_DEPTH];

	localparam longint unsigned Q30_ONE    = 64'd1 << 30;
	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint unsigned SIN_DIV [6] = '{6, 20, 42, 72, 110, 156};
	localparam longint unsigned COS_DIV [6] = '{2, 12, 30, 56, 90, 132};

	function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint unsigned horner(longint unsigned x2, bit sine);
		longint unsigned t;
		t = Q30_ONE;
		for (int i = 5; i >= 0; i--) begin
			if (sine) begin
				t = Q30_ONE - qmul(x2, t) / SIN_DIV[i];
			end else begin
				t = Q30_ONE - qmul(x2, t) / COS_DIV[i];
			end
		end
		return t;
	endfunction

	function automatic tw_t to_tw(longint unsigned q);
		longint unsigned v;
		longint unsigned mx;
		mx = (64'd1 << TW_F) - 64'd1;
		v  = (q + (64'd1 << (29 - TW_F))) >> (30 - TW_F);
		if (v > mx) begin
			v = mx;
		end
		return TW_BITS'(v);
	endfunction

	function automatic rom_t build_rom();
		rom_t            r;
		longint unsigned a, o, rm, rr, x, x2;
		tw_t             c, s, cw, sw;
		for (int m = 0; m < TW_DEPTH; m++) begin
			a  = longint'(m) << (14 - LMAX);
			o  = (a >> 11) & 64'd3;
			rm = a & 64'd2047;
			rr = (o == 64'd1 || o == 64'd3) ? 64'd2048 - rm : rm;
			x  = (rr * TWO_PI_Q30 + 64'd8192) >> 14;
			x2 = qmul(x, x);
			c  = to_tw(horner(x2, 1'b0));
			s  = to_tw(qmul(x, horner(x2, 1'b1)));
			case (o)
				64'd0: begin cw = c;        sw = s; end
				64'd1: begin cw = s;        sw = c; end
				64'd2: begin cw = tw_t'(-s); sw = c; end
				default: begin cw = tw_t'(-c); sw = s; end
			endcase
			r[m] = {cw, sw};
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [2*TW_BITS-1:0] rom_q;

	always_ff @(posedge clk) begin
		rom_q <= ROM[addr];
	end

	assign w_cos = rom_q[2*TW_BITS-1:TW_BITS];
	assign w_sin = rom_q[TW_BITS-1:0];

endmodule

// ----- src/r2fft_bfly.sv -----
// ----------------------------------------------------------------------------
// r2fft_bfly
// Butterfly unit: one shared 32x16 multiplier, four products per butterfly,
// rounding and 32-bit saturation of the sum and difference.
// ----------------------------------------------------------------------------
module r2fft_bfly (
	input  logic                clk,
	input  logic                arst_n,
	input  r2fft_pkg::bf_ctl_t  ctl,
	input  r2fft_pkg::cword_t   a_word,
	input  r2fft_pkg::cword_t   b_word,
	input  r2fft_pkg::tw_t      w_cos,
	input  r2fft_pkg::tw_t      w_sin,
	output logic                done,
	output r2fft_pkg::cword_t   sum_word,
	output r2fft_pkg::cword_t   diff_word
);
	import r2fft_pkg::*;

	localparam int PW  = DW + TW_BITS;
	localparam int ACW = PW + 1;
	localparam int TRW = ACW - TW_F;
	localparam int SW  = TRW + 1;
	localparam logic [3:0] LAST_STEP = 4'd8;

	logic [3:0]               cnt_q;
	word_t                    ar_q, ai_q, xr_q, xi_q;
	tw_t                      wr_q, wi_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [ACW-1:0]    accr_q, acci_q;
	logic signed [TRW-1:0]    tr_q, ti_q;
	cword_t                   sum_q, diff_q;
	word_t                    mul_a;
	tw_t                      mul_b;
	logic signed [PW-1:0]     prod;
	logic signed [ACW-1:0]    rnd_r, rnd_i;
	logic signed [SW-1:0]     s_r, s_i, d_r, d_i;

	function automatic word_t sat32(logic signed [SW-1:0] v);
		if (v > SW'(32'sh7fffffff)) begin
			return 32'sh7fffffff;
		end else if (v < -SW'(33'sh080000000)) begin
			return 32'sh80000000;
		end
		return DW'(v);
	endfunction

	always_comb begin
		case (cnt_q)
			4'd1: begin mul_a = xr_q; mul_b = wr_q; end
			4'd2: begin mul_a = xi_q; mul_b = wi_q; end
			4'd3: begin mul_a = xr_q; mul_b = wi_q; end
			default: begin mul_a = xi_q; mul_b = wr_q; end
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign rnd_r = accr_q + (ACW'(1) <<< (TW_F - 1));
	assign rnd_i = acci_q + (ACW'(1) <<< (TW_F - 1));
	assign s_r   = SW'(ar_q) + SW'(tr_q);
	assign s_i   = SW'(ai_q) + SW'(ti_q);
	assign d_r   = SW'(ar_q) - SW'(tr_q);
	assign d_i   = SW'(ai_q) - SW'(ti_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.go) begin
			cnt_q <= 4'd1;
		end else if (cnt_q == LAST_STEP) begin
			cnt_q <= '0;
		end else if (cnt_q != 4'd0) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			ar_q <= a_word[2*DW-1:DW];
			ai_q <= a_word[DW-1:0];
			xr_q <= b_word[2*DW-1:DW];
			xi_q <= b_word[DW-1:0];
			wr_q <= w_cos;
			wi_q <= ctl.inv ? w_sin : tw_t'(-w_sin);
		end
		prod_q <= prod;
		case (cnt_q)
			4'd2: accr_q <= ACW'(prod_q);
			4'd3: accr_q <= accr_q - ACW'(prod_q);
			4'd4: acci_q <= ACW'(prod_q);
			4'd5: acci_q <= acci_q + ACW'(prod_q);
			4'd6: begin
				tr_q <= TRW'(rnd_r >>> TW_F);
				ti_q <= TRW'(rnd_i >>> TW_F);
			end
			4'd7: begin
				sum_q  <= {sat32(s_r), sat32(s_i)};
				diff_q <= {sat32(d_r), sat32(d_i)};
			end
			default: ;
		endcase
	end

	assign done      = (cnt_q == LAST_STEP);
	assign sum_word  = sum_q;
	assign diff_word = diff_q;

endmodule

// ----- src/radix2_fft_1d.sv -----
// ----------------------------------------------------------------------------
// radix2_fft_1d
// In-place radix-2 decimation-in-time FFT engine with load/read commands.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. command 0
// loads the next sample (sample_re/sample_im), command 1 reads the next bin.
// The load that fills the frame (N = 2^log2_points, log2_points taken as 1
// when 0 and as 10 when above 10) raises busy for the transform: bit
// reversal, L*N/2 butterflies on the single shared multiplier doing four
// products per butterfly, and for inverse a scaling pass. A read returns
// its bin in the cycle after acceptance, on result_re/result_im with
// bin_index and last, marked by result_valid for one cycle; reads may
// follow every cycle. The receiver cannot stall. Reads with no frame ready
// give no result; a load drops unread results. cfg_we/cfg_index/cfg_data
// write inverse (0) and log2_points (1); the user is to write them only
// while idle, which the block itself does not enforce. Reset clears
// counters and state and sets forward mode, log2_points = 10; frame memory
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module radix2_fft_1d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic signed [r2fft_pkg::SMP_W-1:0] sample_re,
	input  logic signed [r2fft_pkg::SMP_W-1:0] sample_im,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [r2fft_pkg::LOG_W-1:0]   cfg_data,
	output logic                          result_valid,
	output logic signed [r2fft_pkg::OW-1:0] result_re,
	output logic signed [r2fft_pkg::OW-1:0] result_im,
	output logic [r2fft_pkg::BIN_W-1:0]   bin_index,
	output logic                          last
);
	import r2fft_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_BR_RD, S_BR_W1, S_BR_W2, S_BF_RD, S_BF_GO, S_BF_WAIT,
		S_BF_WA, S_BF_WB, S_SC_RD, S_SC_W
	} state_t;

	state_t             state_q;
	logic               inv_cfg_q, inv_q;
	logic [LOG_W-1:0]   log_cfg_q, l_q, s_q;
	logic [CW-1:0]      lc_q, rc_q, ci_q, k_q;
	logic               ready_q, valid_q, last_q;
	logic [BIN_W-1:0]   bin_q;

	logic [LOG_W-1:0]   l_eff;
	logic [CW-1:0]      n_cur, n_tr, half_tr, lc_eff, rc_eff, rv, mask, a_idx, b_idx;
	logic [CW-1:0]      rv_full;
	logic [TW_AW-1:0]   tw_addr;
	logic               mem_we;
	logic [AW-1:0]      waddr, raddr0, raddr1;
	cword_t             wdata, rdata0, rdata1, sum_word, diff_word;
	tw_t                w_cos, w_sin;
	bf_ctl_t            bf_ctl;
	logic               bf_done;
	logic               acc_load, acc_read;

	function automatic word_t scale(word_t v, logic [LOG_W-1:0] l);
		logic signed [DW:0] t;
		logic signed [DW:0] m;
		m = ((DW+1)'(1) <<< l) - (DW+1)'(1);
		t = (DW+1)'(v);
		if (v[DW-1]) begin
			t = t + m;
		end
		return DW'(t >>> l);
	endfunction

	function automatic logic signed [OW-1:0] sat27(word_t v);
		if (v > DW'(67108863)) begin
			return OW'(67108863);
		end else if (v < -DW'(67108864)) begin
			return OW'(-67108864);
		end
		return OW'(v);
	endfunction

	always_comb begin
		if (log_cfg_q == '0) begin
			l_eff = LOG_W'(1);
		end else if (log_cfg_q > LOG_W'(LMAX)) begin
			l_eff = LOG_W'(LMAX);
		end else begin
			l_eff = log_cfg_q;
		end
	end

	assign n_cur   = CW'(1) << l_eff;
	assign n_tr    = CW'(1) << l_q;
	assign half_tr = n_tr >> 1;
	assign lc_eff  = (lc_q >= n_cur) ? '0 : lc_q;
	assign rc_eff  = (rc_q >= n_cur) ? '0 : rc_q;

	always_comb begin
		rv_full = '0;
		for (int i = 0; i < AW; i++) begin
			rv_full[AW-1-i] = ci_q[i];
		end
	end
	assign rv = rv_full >> (LOG_W'(AW) - l_q);

	assign mask    = (CW'(1) << s_q) - CW'(1);
	assign a_idx   = ((k_q & ~mask) << 1) | (k_q & mask);
	assign b_idx   = a_idx | (CW'(1) << s_q);
	assign tw_addr = TW_AW'((k_q & mask) << (LOG_W'(LMAX - 1) - s_q));

	assign busy     = (state_q != S_IDLE);
	assign acc_load = start && !busy && (command == CMD_LOAD);
	assign acc_read = start && !busy && (command == CMD_READ);

	always_comb begin
		raddr0 = ci_q[AW-1:0];
		raddr1 = rv[AW-1:0];
		mem_we = 1'b0;
		waddr  = ci_q[AW-1:0];
		wdata  = rdata1;
		unique case (state_q)
			S_IDLE: begin
				raddr0 = rc_eff[AW-1:0];
				mem_we = acc_load;
				waddr  = lc_eff[AW-1:0];
				wdata  = {DW'(sample_re), DW'(sample_im)};
			end
			S_BR_RD: ;
			S_BR_W1: mem_we = 1'b1;
			S_BR_W2: begin
				mem_we = 1'b1;
				waddr  = rv[AW-1:0];
				wdata  = rdata0;
			end
			S_BF_RD, S_BF_GO, S_BF_WAIT: begin
				raddr0 = a_idx[AW-1:0];
				raddr1 = b_idx[AW-1:0];
			end
			S_BF_WA: begin
				mem_we = 1'b1;
				waddr  = a_idx[AW-1:0];
				wdata  = sum_word;
			end
			S_BF_WB: begin
				mem_we = 1'b1;
				waddr  = b_idx[AW-1:0];
				wdata  = diff_word;
			end
			S_SC_RD: ;
			S_SC_W: begin
				mem_we = 1'b1;
				wdata  = {scale(rdata0[2*DW-1:DW], l_q), scale(rdata0[DW-1:0], l_q)};
			end
			default: ;
		endcase
	end

	assign bf_ctl.go  = (state_q == S_BF_GO);
	assign bf_ctl.inv = inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_cfg_q <= 1'b0;
			log_cfg_q <= LOG_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INVERSE: inv_cfg_q <= cfg_data[0];
				CFG_LOG2:    log_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lc_q    <= '0;
			rc_q    <= '0;
			ci_q    <= '0;
			k_q     <= '0;
			s_q     <= '0;
			l_q     <= LOG_W'(1);
			inv_q   <= 1'b0;
			ready_q <= 1'b0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			bin_q   <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc_load) begin
						ready_q <= 1'b0;
						rc_q    <= '0;
						if (lc_eff + CW'(1) == n_cur) begin
							lc_q    <= '0;
							inv_q   <= inv_cfg_q;
							l_q     <= l_eff;
							ci_q    <= '0;
							state_q <= S_BR_RD;
						end else begin
							lc_q <= lc_eff + CW'(1);
						end
					end else if (acc_read && ready_q) begin
						valid_q <= 1'b1;
						bin_q   <= BIN_W'(rc_eff);
						last_q  <= (rc_eff == n_cur - CW'(1));
						if (rc_eff == n_cur - CW'(1)) begin
							rc_q    <= '0;
							ready_q <= 1'b0;
						end else begin
							rc_q <= rc_eff + CW'(1);
						end
					end
				end
				S_BR_RD, S_BR_W2: begin
					if (state_q == S_BR_RD && ci_q < rv) begin
						state_q <= S_BR_W1;
					end else if (ci_q == n_tr - CW'(1)) begin
						k_q     <= '0;
						s_q     <= '0;
						state_q <= S_BF_RD;
					end else begin
						ci_q    <= ci_q + CW'(1);
						state_q <= S_BR_RD;
					end
				end
				S_BR_W1: state_q <= S_BR_W2;
				S_BF_RD: state_q <= S_BF_GO;
				S_BF_GO: state_q <= S_BF_WAIT;
				S_BF_WAIT: begin
					if (bf_done) begin
						state_q <= S_BF_WA;
					end
				end
				S_BF_WA: state_q <= S_BF_WB;
				S_BF_WB: begin
					state_q <= S_BF_RD;
					if (k_q == half_tr - CW'(1)) begin
						k_q <= '0;
						if (s_q == l_q - LOG_W'(1)) begin
							if (inv_q) begin
								ci_q    <= '0;
								state_q <= S_SC_RD;
							end else begin
								ready_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end else begin
							s_q <= s_q + LOG_W'(1);
						end
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_SC_RD: state_q <= S_SC_W;
				S_SC_W: begin
					if (ci_q == n_tr - CW'(1)) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ci_q    <= ci_q + CW'(1);
						state_q <= S_SC_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	r2fft_mem u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	r2fft_twiddle u_twiddle (
		.clk   (clk),
		.addr  (tw_addr),
		.w_cos (w_cos),
		.w_sin (w_sin)
	);

	r2fft_bfly u_bfly (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (bf_ctl),
		.a_word    (rdata0),
		.b_word    (rdata1),
		.w_cos     (w_cos),
		.w_sin     (w_sin),
		.done      (bf_done),
		.sum_word  (sum_word),
		.diff_word (diff_word)
	);

	assign result_valid = valid_q;
	assign result_re    = sat27(rdata0[2*DW-1:DW]);
	assign result_im    = sat27(rdata0[DW-1:0]);
	assign bin_index    = bin_q;
	assign last         = last_q;

endmodule

// ----- src/r2fft_checker.sv -----
// ----------------------------------------------------------------------------
// r2fft_checker
// Port-level checks of the FFT engine's command and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module r2fft_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic command,
	input logic result_valid,
	input logic last
);
	import r2fft_pkg::*;

	// a result only follows an accepted read request
	`ASSERT_IMP(a_valid_after_read, clk, arst_n, result_valid, $past(start && !busy && (command == CMD_READ)))
	// results never show while a transform runs
	`ASSERT_IMP(a_valid_idle, clk, arst_n, result_valid, !busy)
	// busy only starts from a load request
	`ASSERT_IMP(a_busy_from_load, clk, arst_n, $rose(busy), $past(start && (command == CMD_LOAD)))
	// nothing follows the last bin of a frame
	`ASSERT_NXT(a_last_ends, clk, arst_n, result_valid && last, !result_valid)

endmodule

bind radix2_fft_1d r2fft_checker u_r2fft_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.result_valid (result_valid),
	.last         (last)
);
